// File: sv/tpp_pkg.sv
// Types and constants shared by the tape pulse player.
package tpp_pkg;

    // Playback phase of the current tape block
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PILOT,
        PH_SYNC1,
        PH_SYNC2,
        PH_DATA,
        PH_PAUSE
    } phase_t;

    // Command sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP,
        S_BIT,
        S_OPEN0,
        S_OPEN1,
        S_OPEN2,
        S_OPEN3
    } fsm_t;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_LENGTH  = 2'd1;
    localparam logic [1:0] CMD_START   = 2'd2;
    localparam logic [1:0] CMD_ADVANCE = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_END       = 2'd1;
    localparam logic [1:0] STAT_TRUNCATED = 2'd2;

    localparam logic [2:0] REG_PILOT_TICKS = 3'd0;
    localparam logic [2:0] REG_SYNC1_TICKS = 3'd1;
    localparam logic [2:0] REG_SYNC2_TICKS = 3'd2;
    localparam logic [2:0] REG_ZERO_TICKS  = 3'd3;
    localparam logic [2:0] REG_ONE_TICKS   = 3'd4;
    localparam logic [2:0] REG_GAP_TICKS   = 3'd5;
    localparam logic [2:0] REG_HDR_COUNT   = 3'd6;
    localparam logic [2:0] REG_DATA_COUNT  = 3'd7;

    localparam logic [15:0] RST_PILOT_TICKS = 16'd2168;
    localparam logic [15:0] RST_SYNC1_TICKS = 16'd667;
    localparam logic [15:0] RST_SYNC2_TICKS = 16'd735;
    localparam logic [15:0] RST_ZERO_TICKS  = 16'd855;
    localparam logic [15:0] RST_ONE_TICKS   = 16'd1710;
    localparam logic [23:0] RST_GAP_TICKS   = 24'd3500000;
    localparam logic [15:0] RST_HDR_COUNT   = 16'd8063;
    localparam logic [15:0] RST_DATA_COUNT  = 16'd3223;

    localparam logic [7:0] BIT_MSB   = 8'h80;
    localparam logic [7:0] FLAG_HDR  = 8'h00;

    // Signed width of the remaining pulse time: a 24-bit gap plus a tick overrun
    localparam int PR_W = 26;

endpackage

// File: sv/tape_pulse_player.sv
// Tape pulse player: tape memory, block sequencer and pulse timing.
// Latency: write, set length, empty start and stopped advance answer 1 cycle after
// the transfer, a start that opens a block 5 (three tape memory reads); an advance
// takes 2 plus 1 per pilot or first sync edge, 2 per second sync or data edge, 1 for
// the edge that ends a block's data and 5 for the gap edge. Throughput equals latency:
// the next transfer is taken while the result strobe is high. Reset is asynchronous:
// control state and registers take reset values; tape memory is not cleared.
module tape_pulse_player #(
    parameter int TAPE_DEPTH = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          command,
    input  logic [15:0]         tape_address,
    input  logic [7:0]          tape_byte,
    input  logic [16:0]         image_length,
    input  logic [7:0]          elapsed_ticks,
    output logic                done,
    output logic                ear_level,
    output logic                playing,
    output logic [1:0]          status,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);
    import tpp_pkg::*;

    localparam int AW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;

    // Configuration registers
    logic [15:0] pilot_ticks_reg, sync1_ticks_reg, sync2_ticks_reg;
    logic [15:0] zero_ticks_reg, one_ticks_reg, hdr_count_reg, data_count_reg;
    logic [23:0] gap_ticks_reg;

    // Player state
    fsm_t                   state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [16:0]            stored_reg, stored_next;
    logic [16:0]            rp_reg, rp_next;
    logic                   level_reg, level_next;
    logic                   rep_reg, rep_next;
    logic [1:0]             status_reg, status_next;
    logic [15:0]            cur_len_reg, cur_len_next;
    logic [15:0]            bidx_reg, bidx_next;
    logic [7:0]             bsel_reg, bsel_next;
    logic [15:0]            pilot_rem_reg, pilot_rem_next;
    logic signed [PR_W-1:0] pr_reg, pr_next;
    logic                   from_adv_reg, from_adv_next;
    logic                   done_reg, done_next;

    // Tape memory
    logic [7:0]  tape_mem [TAPE_DEPTH];
    logic [7:0]  rd_data_reg;
    logic        rd_ok_reg;
    logic [16:0] rd_addr;
    logic        rd_ok;
    logic        mem_we;
    logic [7:0]  rd_byte;
    logic        accept;
    logic        pr_le0;

    function automatic logic signed [PR_W-1:0] ticks_of(input logic [23:0] v);
        logic [23:0] w;
        w = (v == 24'd0) ? 24'd1 : v;
        return signed'({{(PR_W-24){1'b0}}, w});
    endfunction

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign mem_we  = accept && (command == CMD_WRITE) &&
                     (32'(tape_address) < 32'(TAPE_DEPTH));
    assign rd_ok   = (32'(rd_addr) < 32'(TAPE_DEPTH));
    assign rd_byte = rd_ok_reg ? rd_data_reg : 8'h00;
    assign pr_le0  = pr_reg[PR_W-1] || (pr_reg == '0);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tape_mem[AW'(tape_address)] <= tape_byte;
        end
        rd_data_reg <= tape_mem[AW'(rd_addr)];
        rd_ok_reg   <= rd_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pilot_ticks_reg <= RST_PILOT_TICKS;
            sync1_ticks_reg <= RST_SYNC1_TICKS;
            sync2_ticks_reg <= RST_SYNC2_TICKS;
            zero_ticks_reg  <= RST_ZERO_TICKS;
            one_ticks_reg   <= RST_ONE_TICKS;
            gap_ticks_reg   <= RST_GAP_TICKS;
            hdr_count_reg   <= RST_HDR_COUNT;
            data_count_reg  <= RST_DATA_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PILOT_TICKS: pilot_ticks_reg <= cfg_data[15:0];
                REG_SYNC1_TICKS: sync1_ticks_reg <= cfg_data[15:0];
                REG_SYNC2_TICKS: sync2_ticks_reg <= cfg_data[15:0];
                REG_ZERO_TICKS:  zero_ticks_reg  <= cfg_data[15:0];
                REG_ONE_TICKS:   one_ticks_reg   <= cfg_data[15:0];
                REG_GAP_TICKS:   gap_ticks_reg   <= cfg_data;
                REG_HDR_COUNT:   hdr_count_reg   <= cfg_data[15:0];
                REG_DATA_COUNT:  data_count_reg  <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            stored_reg    <= '0;
            rp_reg        <= '0;
            level_reg     <= 1'b0;
            rep_reg       <= 1'b0;
            status_reg    <= STAT_OK;
            cur_len_reg   <= '0;
            bidx_reg      <= '0;
            bsel_reg      <= BIT_MSB;
            pilot_rem_reg <= '0;
            pr_reg        <= '0;
            from_adv_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            stored_reg    <= stored_next;
            rp_reg        <= rp_next;
            level_reg     <= level_next;
            rep_reg       <= rep_next;
            status_reg    <= status_next;
            cur_len_reg   <= cur_len_next;
            bidx_reg      <= bidx_next;
            bsel_reg      <= bsel_next;
            pilot_rem_reg <= pilot_rem_next;
            pr_reg        <= pr_next;
            from_adv_reg  <= from_adv_next;
            done_reg      <= done_next;
        end
    end

    always_comb
    begin
        logic [16:0] bidx_inc;
        logic [16:0] rp_new;
        logic [15:0] blen;
        logic [15:0] pcount;

        state_next     = state_reg;
        phase_next     = phase_reg;
        stored_next    = stored_reg;
        rp_next        = rp_reg;
        level_next     = level_reg;
        rep_next       = rep_reg;
        status_next    = status_reg;
        cur_len_next   = cur_len_reg;
        bidx_next      = bidx_reg;
        bsel_next      = bsel_reg;
        pilot_rem_next = pilot_rem_reg;
        pr_next        = pr_reg;
        from_adv_next  = from_adv_reg;
        done_next      = 1'b0;
        rd_addr        = rp_reg;
        bidx_inc       = 17'(bidx_reg) + 17'd1;
        rp_new         = rp_reg + 17'd2;
        blen           = {rd_byte, cur_len_reg[7:0]};
        pcount         = (rd_byte == FLAG_HDR) ? hdr_count_reg : data_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_WRITE:
                        begin
                            done_next = 1'b1;
                        end
                        CMD_LENGTH:
                        begin
                            stored_next = (32'(image_length) > 32'(TAPE_DEPTH)) ?
                                          17'(TAPE_DEPTH) : image_length;
                            rp_next     = '0;
                            phase_next  = PH_IDLE;
                            level_next  = 1'b0;
                            rep_next    = 1'b0;
                            status_next = STAT_OK;
                            done_next   = 1'b1;
                        end
                        CMD_START:
                        begin
                            if (stored_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                status_next   = STAT_OK;
                                rp_next       = '0;
                                from_adv_next = 1'b0;
                                state_next    = S_OPEN0;
                            end
                        end
                        CMD_ADVANCE:
                        begin
                            if (phase_reg == PH_IDLE)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                pr_next    = pr_reg -
                                             signed'({{(PR_W-8){1'b0}}, elapsed_ticks});
                                state_next = S_LOOP;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOP:
            begin
                if (!pr_le0)
                begin
                    // Pulse still running: publish the level and finish
                    rep_next   = level_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    level_next = ~level_reg;
                    case (phase_reg)
                        PH_PILOT:
                        begin
                            if (pilot_rem_reg <= 16'd1)
                            begin
                                pilot_rem_next = '0;
                                phase_next     = PH_SYNC1;
                                pr_next        = pr_reg + ticks_of(24'(sync1_ticks_reg));
                            end
                            else
                            begin
                                pilot_rem_next = pilot_rem_reg - 16'd1;
                                pr_next        = pr_reg + ticks_of(24'(pilot_ticks_reg));
                            end
                        end
                        PH_SYNC1:
                        begin
                            phase_next = PH_SYNC2;
                            pr_next    = pr_reg + ticks_of(24'(sync2_ticks_reg));
                        end
                        PH_SYNC2:
                        begin
                            phase_next = PH_DATA;
                            bidx_next  = '0;
                            bsel_next  = BIT_MSB;
                            rd_addr    = rp_reg;
                            state_next = S_BIT;
                        end
                        PH_DATA:
                        begin
                            rd_addr    = rp_reg + 17'(bidx_reg);
                            state_next = S_BIT;
                            // Bit boundary where the level falls
                            if (level_reg)
                            begin
                                bsel_next = bsel_reg >> 1;
                                if (bsel_reg[0])
                                begin
                                    bsel_next = BIT_MSB;
                                    bidx_next = bidx_inc[15:0];
                                    rd_addr   = rp_reg + bidx_inc;
                                    if (bidx_inc >= 17'(cur_len_reg))
                                    begin
                                        rp_next    = rp_reg + 17'(cur_len_reg);
                                        phase_next = PH_PAUSE;
                                        pr_next    = pr_reg + ticks_of(gap_ticks_reg);
                                        state_next = S_LOOP;
                                    end
                                end
                            end
                        end
                        PH_PAUSE:
                        begin
                            level_next    = 1'b0;
                            from_adv_next = 1'b1;
                            state_next    = S_OPEN0;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_BIT:
            begin
                pr_next    = pr_reg + ticks_of(((rd_byte & bsel_reg) != 8'h00) ?
                                               24'(one_ticks_reg) : 24'(zero_ticks_reg));
                state_next = S_LOOP;
            end
            S_OPEN0:
            begin
                if ((18'(rp_reg) + 18'd2) > 18'(stored_reg))
                begin
                    phase_next  = PH_IDLE;
                    status_next = STAT_END;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_addr    = rp_reg;
                    state_next = S_OPEN1;
                end
            end
            S_OPEN1:
            begin
                // Hold the low length byte, fetch the high one
                cur_len_next = {8'h00, rd_byte};
                rd_addr      = rp_reg + 17'd1;
                state_next   = S_OPEN2;
            end
            S_OPEN2:
            begin
                cur_len_next = blen;
                rp_next      = rp_new;
                if ((18'(rp_new) + 18'(blen)) > 18'(stored_reg))
                begin
                    phase_next  = PH_IDLE;
                    status_next = STAT_TRUNCATED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_addr    = rp_new;
                    state_next = S_OPEN3;
                end
            end
            S_OPEN3:
            begin
                bidx_next      = '0;
                bsel_next      = BIT_MSB;
                pilot_rem_next = (pcount == 16'd0) ? 16'd1 : pcount;
                phase_next     = PH_PILOT;
                pr_next        = ticks_of(24'(pilot_ticks_reg));
                level_next     = 1'b1;
                if (from_adv_reg)
                begin
                    state_next = S_LOOP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done      = done_reg;
    assign ear_level = rep_reg;
    assign playing   = (phase_reg != PH_IDLE);
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while a command is still in progress");

    a_pulse_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && (phase_reg != PH_IDLE)) |-> !pr_le0)
        else $error("idle while playing with no pulse time left");

    a_stopped_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_ADVANCE) && (phase_reg == PH_IDLE)) |=> done_reg)
        else $error("advance while stopped did not finish at once");

    a_error_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && (status_reg != STAT_OK)) |-> (phase_reg == PH_IDLE))
        else $error("error status reported while still playing");

    a_bit_select: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(bsel_reg))
        else $error("bit select lost its single set bit");
`endif

endmodule
